@@ rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // Input and result beats
  typedef struct packed {
    logic [7:0] data_byte;
    logic       terminator;
  } u8u16_in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
  } u8u16_out_t;

  // Command from the front to the back: replacement units first, then a tail
  typedef struct packed {
    logic [1:0]  n_repl;    // FFFD units for a flushed sequence (0..3)
    logic [1:0]  tail_cnt;  // tail units after the replacements (0..2)
    logic        is_end;    // tail is the string terminator unit
    logic [15:0] unit0;     // first tail unit
    logic [15:0] unit1;     // second tail unit (low surrogate)
  } u8u16_cmd_t;

  // Command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Code constants
  localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] BMP_LO_MAX = 21'h00D7FF;
  localparam logic [20:0] BMP_HI_MIN = 21'h00E000;
  localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

endpackage

@@ rtl/utf8_to_utf16_transcoder_top.sv @@
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   Channel  Direction  Payload      Meaning
//   in_      in         u8u16_in_t   one UTF-8 byte or a string terminator
//   out_     out        u8u16_out_t  one UTF-16 code unit with end marks
//
// One input beat is taken per cycle while the four-entry command queue has room.
// Each command drains at one code unit per cycle from the output register while
// out_ready holds; a byte causes k units (k from 1 to 4), or none while a sequence stays open.
// A byte's command passes through the queue and then the output register before its units appear on out_.
// rst_n is synchronous; it clears the sequence state, queue and output valid.
// Stalls on out_ back up the queue; in_ready drops only when the queue is full.
module utf8_to_utf16_transcoder_top import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  u8u16_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output u8u16_out_t out_data
);

  u8u16_cmd_t push_cmd, head_cmd;
  logic       push, pop, head_valid, q_full;

  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .full       (q_full)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ rtl/u8u16_front.sv @@
// Front end: takes UTF-8 bytes, tracks the open sequence, issues unit commands.
module u8u16_front import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  u8u16_in_t  in_data,
  input  logic       q_full,
  output logic       cmd_push,
  output u8u16_cmd_t cmd
);

  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  gathered_r, gathered_nxt;
  logic [20:0] pv_r, pv_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        is_cont;
  logic        pending;
  logic [1:0]  flush_cnt;
  logic [20:0] pv_shift;
  logic        seq_done;
  logic [20:0] cp_off;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign is_cont  = (b[7:6] == 2'b10);
  assign pending  = (needed_r != 2'd0);
  assign flush_cnt = pending ? (gathered_r + 2'd1) : 2'd0;
  assign pv_shift = {pv_r[14:0], b[5:0]};
  assign seq_done = ({1'b0, gathered_r} + 3'd1) >= {1'b0, needed_r};
  assign cp_off   = pv_shift - SUPP_BASE;

  // Classify the beat into a command and the next sequence state
  always_comb begin
    needed_nxt   = needed_r;
    gathered_nxt = gathered_r;
    pv_nxt       = pv_r;
    cmd          = '0;
    if (in_data.terminator) begin
      cmd.n_repl   = flush_cnt;
      cmd.tail_cnt = 2'd1;
      cmd.is_end   = 1'b1;
      needed_nxt   = 2'd0;
      gathered_nxt = 2'd0;
      pv_nxt       = '0;
    end else if (pending && is_cont) begin
      if (seq_done) begin
        needed_nxt   = 2'd0;
        gathered_nxt = 2'd0;
        pv_nxt       = '0;
        cmd.tail_cnt = 2'd1;
        if (pv_shift <= BMP_LO_MAX ||
            (pv_shift >= BMP_HI_MIN && pv_shift <= BMP_MAX)) begin
          cmd.unit0 = pv_shift[15:0];
        end else if (pv_shift >= SUPP_BASE && pv_shift <= CP_MAX) begin
          cmd.tail_cnt = 2'd2;
          cmd.unit0    = HI_SURR | {6'd0, cp_off[19:10]};
          cmd.unit1    = LO_SURR | {6'd0, cp_off[9:0]};
        end else begin
          cmd.unit0 = REPL_UNIT;
        end
      end else begin
        gathered_nxt = gathered_r + 2'd1;
        pv_nxt       = pv_shift;
      end
    end else begin
      // Flush whatever is open, then decode the byte from scratch
      cmd.n_repl   = flush_cnt;
      needed_nxt   = 2'd0;
      gathered_nxt = 2'd0;
      pv_nxt       = '0;
      if (b[7] == 1'b0) begin
        cmd.tail_cnt = 2'd1;
        cmd.unit0    = {8'd0, b};
      end else if (b[7:5] == 3'b110) begin
        needed_nxt = 2'd1;
        pv_nxt     = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        needed_nxt = 2'd2;
        pv_nxt     = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        needed_nxt = 2'd3;
        pv_nxt     = {18'd0, b[2:0]};
      end else begin
        cmd.tail_cnt = 2'd1;
        cmd.unit0    = REPL_UNIT;
      end
    end
  end

  // Beats that produce no unit leave nothing in the queue
  assign cmd_push = accept && ((cmd.n_repl != 2'd0) || (cmd.tail_cnt != 2'd0));

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r   <= 2'd0;
      gathered_r <= 2'd0;
      pv_r       <= '0;
    end else if (accept) begin
      needed_r   <= needed_nxt;
      gathered_r <= gathered_nxt;
      pv_r       <= pv_nxt;
    end
  end

  // Gathered count stays below the sequence length
  a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (needed_r != 2'd0) |-> (gathered_r < needed_r))
    else $error("gathered count reached sequence length");

  // Idle state holds no partial value
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (needed_r == 2'd0) |-> (pv_r == '0 && gathered_r == 2'd0))
    else $error("partial value left over with no open sequence");

endmodule

@@ rtl/u8u16_queue.sv @@
// Short command queue between the front and back ends.
module u8u16_queue import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u8u16_cmd_t push_cmd,
  input  logic       pop,
  output u8u16_cmd_t head_cmd,
  output logic       head_valid,
  output logic       full
);

  u8u16_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

@@ rtl/u8u16_back.sv @@
// Back end: expands queued commands into UTF-16 units, one per beat.
module u8u16_back import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  u8u16_cmd_t head_cmd,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output u8u16_out_t out_data
);

  logic [1:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  u8u16_out_t  out_data_r, out_data_nxt;

  logic        load;
  logic [2:0]  total;
  logic        last;
  logic [1:0]  tail_idx;

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign total    = {1'b0, head_cmd.n_repl} + {1'b0, head_cmd.tail_cnt};
  assign last     = ({1'b0, step_r} + 3'd1) == total;
  assign tail_idx = step_r - head_cmd.n_repl;
  assign pop      = load && last;

  // Pick the unit for the current step
  always_comb begin
    out_data_nxt          = out_data_r;
    out_valid_nxt         = out_valid_r;
    step_nxt              = step_r;
    if (load) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.run_last   = last;
      out_data_nxt.string_end = 1'b0;
      if (step_r < head_cmd.n_repl) begin
        out_data_nxt.code_unit = REPL_UNIT;
      end else if (head_cmd.is_end) begin
        out_data_nxt.code_unit  = 16'd0;
        out_data_nxt.string_end = 1'b1;
      end else if (tail_idx == 2'd0) begin
        out_data_nxt.code_unit = head_cmd.unit0;
      end else begin
        out_data_nxt.code_unit = head_cmd.unit1;
      end
      step_nxt = last ? 2'd0 : (step_r + 2'd1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Output register and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_end_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.string_end) |->
      (out_data_r.code_unit == 16'd0 && out_data_r.run_last))
    else $error("terminator unit not zero or not last");

  a_step_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, step_r} < total))
    else $error("step counter ran past command");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the UTF-8 to UTF-16 transcoder with a scoreboard class.
module tb_top;
  import u8u16_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  // Predicts the UTF-16 units for each accepted byte and checks the output beats
  class u8u16_scoreboard;
    logic [1:0]  need_cnt;
    logic [1:0]  got_cnt;
    logic [20:0] cp_acc;
    u8u16_out_t  expected_units[$];
    int          fail_cnt;
    int          unit_cnt;
    int          pair_cnt;

    function new();
      need_cnt = '0;
      got_cnt  = '0;
      cp_acc   = '0;
      fail_cnt = 0;
      unit_cnt = 0;
      pair_cnt = 0;
    endfunction

    function void push_unit(logic [15:0] unit, logic is_end);
      u8u16_out_t r;
      r.code_unit  = unit;
      r.run_last   = 1'b0;
      r.string_end = is_end;
      expected_units.push_back(r);
    endfunction

    // BMP value, surrogate pair, or replacement for surrogates and out-of-range
    function void push_code_point(logic [20:0] cp);
      logic [20:0] off;
      off = cp - SUPP_BASE;
      if (cp <= BMP_LO_MAX || (cp >= BMP_HI_MIN && cp <= BMP_MAX)) begin
        push_unit(cp[15:0], 1'b0);
      end else if (cp >= SUPP_BASE && cp <= CP_MAX) begin
        push_unit(HI_SURR | {6'd0, off[19:10]}, 1'b0);
        push_unit(LO_SURR | {6'd0, off[9:0]}, 1'b0);
        pair_cnt++;
      end else begin
        push_unit(REPL_UNIT, 1'b0);
      end
    endfunction

    // One FFFD for the lead plus one per gathered continuation byte
    function void flush_sequence();
      if (need_cnt != 0) begin
        for (int i = 0; i <= int'(got_cnt); i++) push_unit(REPL_UNIT, 1'b0);
      end
      need_cnt = '0;
      got_cnt  = '0;
      cp_acc   = '0;
    endfunction

    function void start_fresh(logic [7:0] b);
      if (!b[7]) begin
        push_unit({8'd0, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        need_cnt = 2'd1;
        got_cnt  = '0;
        cp_acc   = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need_cnt = 2'd2;
        got_cnt  = '0;
        cp_acc   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need_cnt = 2'd3;
        got_cnt  = '0;
        cp_acc   = {18'd0, b[2:0]};
      end else begin
        // stray continuation or F8-FF
        push_unit(REPL_UNIT, 1'b0);
      end
    endfunction

    function void note_beat(u8u16_in_t beat);
      int          first;
      logic [20:0] cp;
      u8u16_out_t  r;
      first = expected_units.size();
      if (beat.terminator) begin
        flush_sequence();
        push_unit(16'h0000, 1'b1);
      end else if (need_cnt != 0 && beat.data_byte[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], beat.data_byte[5:0]};
        if (int'(got_cnt) + 1 >= int'(need_cnt)) begin
          cp       = cp_acc;
          need_cnt = '0;
          got_cnt  = '0;
          cp_acc   = '0;
          push_code_point(cp);
        end else begin
          got_cnt = got_cnt + 2'd1;
        end
      end else begin
        flush_sequence();
        start_fresh(beat.data_byte);
      end
      // mark the last unit caused by this byte
      if (expected_units.size() > first) begin
        r = expected_units.pop_back();
        r.run_last = 1'b1;
        expected_units.push_back(r);
      end
    endfunction

    function void check_unit(u8u16_out_t got);
      u8u16_out_t want;
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected unit %h last %b end %b", $time,
                 got.code_unit, got.run_last, got.string_end);
        fail_cnt++;
        return;
      end
      want = expected_units.pop_front();
      unit_cnt++;
      if (got.code_unit !== want.code_unit || got.run_last !== want.run_last ||
          got.string_end !== want.string_end) begin
        $display("%0t: mismatch expected unit %h last %b end %b, got unit %h last %b end %b",
                 $time, want.code_unit, want.run_last, want.string_end,
                 got.code_unit, got.run_last, got.string_end);
        fail_cnt++;
      end
    endfunction

    function int pending();
      return expected_units.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  u8u16_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  u8u16_out_t out_data;

  u8u16_scoreboard sb = new();

  int send_idle = 0;
  int recv_idle = 0;
  int beats_in = 0;
  int terms_in = 0;
  int stall_cycles = 0;

  utf8_to_utf16_transcoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Beat monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_unit(out_data);
      if (in_valid && in_ready) begin
        sb.note_beat(in_data);
        beats_in++;
        if (in_data.terminator) terms_in++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Present one beat, with an optional idle gap first, and hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic term);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid           <= 1'b1;
    in_data.data_byte  <= b;
    in_data.terminator <= term;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly well-formed sequences with random payload; some cut short, noise, ends
  task automatic send_rand_seq(inout int sent);
    int         roll;
    int         len;
    int         cut;
    logic [7:0] lead;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      sent++;
    end else if (roll < 16) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
      sent++;
    end else begin
      len = $urandom_range(1, 4);
      cut = len;
      if (len > 1 && $urandom_range(0, 99) < 12) cut = $urandom_range(1, len - 1);
      case (len)
        1: lead = 8'($urandom_range(0, 127));
        2: lead = 8'hC0 | 8'($urandom_range(0, 31));
        3: lead = 8'hE0 | 8'($urandom_range(0, 15));
        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      send_beat(lead, 1'b0);
      sent++;
      for (int i = 1; i < cut; i++) begin
        send_beat({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int count);
    int sent;
    sent = 0;
    while (sent < count) send_rand_seq(sent);
  endtask

  // Main sequence
  initial begin
    logic [7:0] directed_bytes[25];
    directed_bytes = '{
      8'h00,                          // zero data byte, not a terminator
      8'hC3, 8'hA9,                   // two-byte sequence
      8'hE2, 8'h82, 8'hAC,            // three-byte sequence
      8'hF0, 8'h9F, 8'h98, 8'h80,     // four-byte, surrogate pair
      8'hED, 8'hA0, 8'h80,            // decodes to a surrogate value
      8'hF7, 8'hBF, 8'hBF, 8'hBF,     // above the code point range
      8'h80,                          // stray continuation
      8'hFF,                          // invalid lead
      8'hE2, 8'h82, 8'h41,            // broken by ASCII
      8'hF0, 8'h9F, 8'h98             // left open for the terminator
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    send_idle = 8;
    recv_idle = 80;
    foreach (directed_bytes[i]) send_beat(directed_bytes[i], 1'b0);
    send_beat(8'hFF, 1'b1);  // end inside a sequence, data byte ignored
    random_phase(28);

    // sender mostly idle, receiver mostly ready
    send_idle = 80;
    recv_idle = 8;
    random_phase(28);

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    random_phase(28);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input beats (%0d terminators) and %0d checked code units,",
             beats_in, terms_in, sb.unit_cnt);
    $display("including %0d surrogate pairs, under three backpressure mixes.", sb.pair_cnt);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
